@@ src/skid_steer_duty_mixer_macros.svh @@
// ----------------------------------------------------------------------------
// skid_steer_duty_mixer_macros.svh
// Assertion helpers for the skid-steer duty mixer. The macros expect clk and
// rst_n to be in scope.
// ----------------------------------------------------------------------------
`ifndef SKID_STEER_DUTY_MIXER_MACROS_SVH
`define SKID_STEER_DUTY_MIXER_MACROS_SVH

// same-cycle implication
`define SSDM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skid steer mixer: same-cycle check failed");

// next-cycle implication
`define SSDM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skid steer mixer: next-cycle check failed");

`endif

@@ src/ssdm_pkg.sv @@
// ----------------------------------------------------------------------------
// ssdm_pkg
// Types, register codes, reset values and divider interface shared by the
// skid-steer duty mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package ssdm_pkg;

    localparam int CFG_W            = 32;
    localparam int CFG_INDEX_W      = 3;
    localparam int MAX_POINTS       = 6;
    localparam int SCALE_POINTS_DEF = 6;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_START  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEEP   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POINT0 = 3'd2;

    // command kinds
    localparam logic [1:0] KIND_SINGLE  = 2'd0;
    localparam logic [1:0] KIND_DIFF    = 2'd1;
    localparam int         KIND_RAW_BIT = 1;

    // register reset values
    localparam logic [CFG_W-1:0] START_RESET = 32'd75171103;
    localparam logic [CFG_W-1:0] KEEP_RESET  = 32'd42927063;
    localparam logic [CFG_W-1:0] POINT_RESET [MAX_POINTS] = '{
        32'd667878359, 32'd858981499, 32'd876152095,
        32'd930940518, 32'd942737326, 32'd948111606
    };

    // fixed-point constants
    localparam logic [16:0] ONE_Q15   = 17'd32768;
    localparam logic [15:0] ONE_Q14   = 16'd16384;
    localparam logic [16:0] ANG_LIMIT = 17'd3277;

    // shared divider shape: quotient known to fit DIV_Q_W bits
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_Q_W   = 16;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] duty_a;
        logic signed [15:0] duty_b;
        logic               apply_scale;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_duty;
        logic signed [15:0] right_duty;
        logic               moving;
    } out_item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ src/ssdm_div.sv @@
// ----------------------------------------------------------------------------
// ssdm_div
// Restoring unsigned divider, one quotient bit per cycle. The caller makes
// sure the upper half of the numerator is below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ssdm_pkg::div_req_t req,
    output ssdm_pkg::div_rsp_t rsp
);

    localparam int QW   = ssdm_pkg::DIV_Q_W;
    localparam int DW   = ssdm_pkg::DIV_DEN_W;
    localparam int CNTW = $clog2(QW);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   den_reg;
    logic [QW-1:0]   low_reg;
    logic [QW-1:0]   quot_reg;

    logic [DW:0]     trial;
    logic            fits;

    assign trial = {rem_reg, low_reg[QW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(QW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= DW'(req.num[ssdm_pkg::DIV_NUM_W-1:QW]);
            low_reg <= req.num[QW-1:0];
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
            low_reg  <= {low_reg[QW-2:0], 1'b0};
            quot_reg <= {quot_reg[QW-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

@@ src/skid_steer_duty_mixer.sv @@
// ----------------------------------------------------------------------------
// skid_steer_duty_mixer
// Skid-steer duty command stage: single, differential and raw commands turned
// into a saturated left/right Q1.15 duty pair plus a moving flag.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_stall  kind, duty_a, duty_b, apply_scale
//  out       source     out_valid/out_stall  left_duty, right_duty, moving
//  cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  single and differential commands may use the shared 16-step divider
//  (run up to three times: both normalizations and the interpolation)
//  and the table search, one point per cycle. in_stall is high from
//  accept until the result is registered.
//  reset clears the moving flag and loads the register defaults.
//  a stalled result holds; the next request may enter behind it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "skid_steer_duty_mixer_macros.svh"

module skid_steer_duty_mixer #(
    parameter int SCALE_POINTS = ssdm_pkg::SCALE_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  ssdm_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output ssdm_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ssdm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ssdm_pkg::CFG_W-1:0]          cfg_data
);

    localparam int IDX_W = $clog2(SCALE_POINTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCALE_POINTS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX,          // decide on normalization
        S_NORM_L,       // left quotient in flight
        S_NORM_R,       // right quotient in flight
        S_CHECK,        // decide on right-wheel scaling
        S_EDGE,         // clamp at table ends
        S_SEARCH,       // walk the table one pair a cycle
        S_MUL_INTERP,
        S_DIV_INTERP,
        S_WAIT_INTERP,
        S_MUL_SCALE,
        S_APPLY_SCALE,
        S_DONE          // gate, saturate, hand off
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0] start_thr_reg;
    logic [31:0] keep_thr_reg;
    logic [31:0] point_reg [SCALE_POINTS];

    logic [ssdm_pkg::CFG_INDEX_W-1:0] pt_off;
    logic                             cfg_wr;
    logic                             pt_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign pt_off    = cfg_index - ssdm_pkg::REG_POINT0;
    assign pt_wr     = cfg_wr && (cfg_index >= ssdm_pkg::REG_POINT0)
                       && (int'(pt_off) < SCALE_POINTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_thr_reg <= ssdm_pkg::START_RESET;
            keep_thr_reg  <= ssdm_pkg::KEEP_RESET;
            for (int i = 0; i < SCALE_POINTS; i++)
            begin
                point_reg[i] <= ssdm_pkg::POINT_RESET[i];
            end
        end
        else
        begin
            if (cfg_wr && cfg_index == ssdm_pkg::REG_START)
            begin
                start_thr_reg <= cfg_data;
            end
            if (cfg_wr && cfg_index == ssdm_pkg::REG_KEEP)
            begin
                keep_thr_reg <= cfg_data;
            end
            for (int i = 0; i < SCALE_POINTS; i++)
            begin
                if (pt_wr && pt_off == ssdm_pkg::CFG_INDEX_W'(i))
                begin
                    point_reg[i] <= cfg_data;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [18:0] mag19(input logic signed [18:0] v);
        return v[18] ? 19'(-v) : 19'(v);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        logic signed [15:0] res;
        if (v > 19'sd32767)
        begin
            res = 16'sh7fff;
        end
        else if (v < -19'sd32768)
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = v[15:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t                  state_reg;
    logic [1:0]              kind_reg;
    logic signed [15:0]      a_reg;
    logic signed [15:0]      b_reg;
    logic                    apply_reg;
    logic signed [18:0]      l_reg;         // unsaturated left, grows past Q1.15
    logic signed [18:0]      r_reg;         // unsaturated right, up to 4x after scaling
    logic [15:0]             d_reg;         // |right| used as table lookup duty
    logic [IDX_W-1:0]        idx_reg;
    logic [31:0]             prev_reg;      // lower point of the bracket
    logic [31:0]             cur_reg;       // upper point of the bracket
    logic [15:0]             scale_reg;     // Q2.14
    logic signed [33:0]      prod_reg;
    logic                    moving_reg;
    logic                    out_valid_reg;
    ssdm_pkg::out_item_t     out_data_reg;

    ssdm_pkg::div_req_t      div_req;
    ssdm_pkg::div_rsp_t      div_rsp;

    logic                    accept;
    logic [18:0]             abs_l;
    logic [18:0]             abs_r;
    logic [16:0]             max_mag;
    logic                    need_norm;
    logic [16:0]             abs_b;
    logic                    scale_on;
    logic [31:0]             cur_pt;
    logic                    bracket;
    logic [33:0]             prod_mag;
    logic [16:0]             span;
    logic signed [16:0]      mul_a;
    logic signed [16:0]      mul_b;
    logic signed [33:0]      mul_p;
    logic [17:0]             interp_sum;
    logic [16:0]             scaled_mag;
    logic [31:0]             thr;
    logic                    gate_pass;
    logic signed [18:0]      fin_l;
    logic signed [18:0]      fin_r;
    logic                    fin_mov;
    logic                    out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign abs_l     = mag19(l_reg);
    assign abs_r     = mag19(r_reg);
    assign max_mag   = (abs_l > abs_r) ? abs_l[16:0] : abs_r[16:0];
    assign need_norm = (max_mag > ssdm_pkg::ONE_Q15);

    // near-straight forward test for differential, positive duty with apply_scale for single
    assign abs_b     = b_reg[15] ? 17'(-{b_reg[15], b_reg}) : {1'b0, b_reg};
    assign scale_on  = (kind_reg == ssdm_pkg::KIND_DIFF)
                       ? (a_reg > 16'sd0 && abs_b < ssdm_pkg::ANG_LIMIT)
                       : (apply_reg && a_reg > 16'sd0);

    // table walk reads one point a cycle
    assign cur_pt    = point_reg[idx_reg];
    assign bracket   = (d_reg >= prev_reg[15:0]) && (d_reg <= cur_pt[15:0]);

    assign prod_mag  = prod_reg[33] ? 34'(-prod_reg) : 34'(prod_reg);
    assign span      = {1'b0, cur_reg[15:0]} - {1'b0, prev_reg[15:0]};

    // shared multiplier: interpolation product or right-wheel scaling
    always_comb
    begin
        if (state_reg == S_MUL_SCALE)
        begin
            mul_a = {1'b0, d_reg};
            mul_b = {1'b0, scale_reg};
        end
        else
        begin
            mul_a = {1'b0, 16'(d_reg - prev_reg[15:0])};
            mul_b = {1'b0, cur_reg[31:16]} - {1'b0, prev_reg[31:16]};
        end
    end
    assign mul_p = mul_a * mul_b;

    // quotient truncated toward zero, sign from the product
    assign interp_sum = {2'b00, prev_reg[31:16]}
                        + (prod_reg[33] ? 18'(-{2'b00, div_rsp.quot})
                                        : {2'b00, div_rsp.quot});
    assign scaled_mag = prod_reg[30:14];

    // shared divider requests
    always_comb
    begin
        div_req.start = ((state_reg == S_MIX) && need_norm)
                        || ((state_reg == S_NORM_L) && div_rsp.done)
                        || (state_reg == S_DIV_INTERP);
        if (state_reg == S_MIX)
        begin
            div_req.num = {abs_l[16:0], 15'd0};
            div_req.den = max_mag;
        end
        else if (state_reg == S_NORM_L)
        begin
            div_req.num = {abs_r[16:0], 15'd0};
            div_req.den = max_mag;
        end
        else
        begin
            div_req.num = prod_mag[31:0];
            div_req.den = span;
        end
    end

    ssdm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // start/keep gate on unsaturated values, raw passes straight through
    assign thr       = moving_reg ? keep_thr_reg : start_thr_reg;
    assign gate_pass = (l_reg > 19'sd0 || r_reg > 19'sd0)
                       && !(l_reg < $signed({3'b000, thr[15:0]}))
                       && !(r_reg < $signed({3'b000, thr[31:16]}));

    always_comb
    begin
        if (kind_reg[ssdm_pkg::KIND_RAW_BIT])
        begin
            fin_l   = l_reg;
            fin_r   = r_reg;
            fin_mov = (l_reg != '0) || (r_reg != '0);
        end
        else
        begin
            fin_l   = gate_pass ? l_reg : '0;
            fin_r   = gate_pass ? r_reg : '0;
            fin_mov = gate_pass;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            moving_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result may replace the one leaving in the same cycle
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_MIX;
                    end
                end
                S_MIX:
                begin
                    if (kind_reg[ssdm_pkg::KIND_RAW_BIT])
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (kind_reg == ssdm_pkg::KIND_DIFF && need_norm)
                    begin
                        state_reg <= S_NORM_L;
                    end
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_NORM_L:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_NORM_R;
                    end
                end
                S_NORM_R:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    state_reg <= scale_on ? S_EDGE : S_DONE;
                end
                S_EDGE:
                begin
                    if (d_reg <= point_reg[0][15:0]
                        || d_reg >= point_reg[SCALE_POINTS-1][15:0])
                    begin
                        state_reg <= S_MUL_SCALE;
                    end
                    else
                    begin
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (bracket)
                    begin
                        state_reg <= (cur_pt[15:0] == prev_reg[15:0])
                                     ? S_MUL_SCALE : S_MUL_INTERP;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_MUL_SCALE;
                    end
                end
                S_MUL_INTERP:
                begin
                    state_reg <= S_DIV_INTERP;
                end
                S_DIV_INTERP:
                begin
                    state_reg <= S_WAIT_INTERP;
                end
                S_WAIT_INTERP:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_MUL_SCALE;
                    end
                end
                S_MUL_SCALE:
                begin
                    state_reg <= S_APPLY_SCALE;
                end
                S_APPLY_SCALE:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        moving_reg <= fin_mov;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_reg  <= in_data.kind;
                    a_reg     <= in_data.duty_a;
                    b_reg     <= in_data.duty_b;
                    apply_reg <= in_data.apply_scale;
                    // mix formed here; raw and single copy the duties
                    if (in_data.kind[ssdm_pkg::KIND_RAW_BIT])
                    begin
                        l_reg <= 19'(in_data.duty_a);
                        r_reg <= 19'(in_data.duty_b);
                    end
                    else if (in_data.kind == ssdm_pkg::KIND_DIFF)
                    begin
                        l_reg <= 19'(in_data.duty_a) + 19'(in_data.duty_b);
                        r_reg <= 19'(in_data.duty_a) - 19'(in_data.duty_b);
                    end
                    else
                    begin
                        l_reg <= 19'(in_data.duty_a);
                        r_reg <= 19'(in_data.duty_a);
                    end
                end
            end
            S_NORM_L:
            begin
                if (div_rsp.done)
                begin
                    l_reg <= l_reg[18] ? 19'(-{3'b000, div_rsp.quot})
                                       : {3'b000, div_rsp.quot};
                end
            end
            S_NORM_R:
            begin
                if (div_rsp.done)
                begin
                    r_reg <= r_reg[18] ? 19'(-{3'b000, div_rsp.quot})
                                       : {3'b000, div_rsp.quot};
                end
            end
            S_CHECK:
            begin
                d_reg <= abs_r[15:0];
            end
            S_EDGE:
            begin
                if (d_reg <= point_reg[0][15:0])
                begin
                    scale_reg <= point_reg[0][31:16];
                end
                else if (d_reg >= point_reg[SCALE_POINTS-1][15:0])
                begin
                    scale_reg <= point_reg[SCALE_POINTS-1][31:16];
                end
                else
                begin
                    prev_reg <= point_reg[0];
                    idx_reg  <= IDX_W'(1);
                end
            end
            S_SEARCH:
            begin
                if (bracket)
                begin
                    // equal neighbor duties take the lower point's scale
                    scale_reg <= prev_reg[31:16];
                    cur_reg   <= cur_pt;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    // unordered table, unity scale
                    scale_reg <= ssdm_pkg::ONE_Q14;
                end
                else
                begin
                    prev_reg <= cur_pt;
                    idx_reg  <= idx_reg + 1'b1;
                end
            end
            S_MUL_INTERP:
            begin
                prod_reg <= mul_p;
            end
            S_WAIT_INTERP:
            begin
                if (div_rsp.done)
                begin
                    scale_reg <= interp_sum[15:0];
                end
            end
            S_MUL_SCALE:
            begin
                prod_reg <= mul_p;
            end
            S_APPLY_SCALE:
            begin
                r_reg <= r_reg[18] ? 19'(-{2'b00, scaled_mag})
                                   : {2'b00, scaled_mag};
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg.left_duty  <= sat16(fin_l);
                    out_data_reg.right_duty <= sat16(fin_r);
                    out_data_reg.moving     <= fin_mov;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `SSDM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `SSDM_ASSERT_NOW(a_moving_has_drive, out_valid && out_data.moving,
        out_data.left_duty != 16'sd0 || out_data.right_duty != 16'sd0)
    `SSDM_ASSERT_NOW(a_div_done_awaited, div_rsp.done,
        state_reg == S_NORM_L || state_reg == S_NORM_R || state_reg == S_WAIT_INTERP)

endmodule

`default_nettype wire

@@ verif/skid_steer_duty_mixer_tb.sv @@
// ----------------------------------------------------------------------------
// skid_steer_duty_mixer_tb
// Self-checking bench for the skid-steer duty mixer. Drives single,
// differential and raw requests through random sender bursts and receiver
// stalls. Reprograms thresholds and the scale table between phases. Checks
// every result against a cycle-free predictor kept in a small scoreboard.
// ----------------------------------------------------------------------------
module skid_steer_duty_mixer_tb;

    import ssdm_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 11;
    localparam int QUIET_LIMIT  = 3000;   // cycles with no handshake of any kind
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 230;
    localparam int SETTLE_WAIT  = 80;

    // raw kinds: bit 1 set selects raw, kind three included
    localparam logic [1:0] KIND_RAW    = 2'd2;
    localparam logic [1:0] KIND_RAW_HI = 2'd3;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the registers and the moving flag, predicts the
    // duty pair for each accepted request and checks results in order
    // ------------------------------------------------------------------------
    class duty_pair_tracker;
        bit [31:0] start_thr;
        bit [31:0] keep_thr;
        bit [31:0] scale_pts [MAX_POINTS];
        bit        moving_now;
        out_item_t expected_duties [$];
        int        mismatches;

        function new();
            int i;
            start_thr = START_RESET;
            keep_thr  = KEEP_RESET;
            for (i = 0; i < MAX_POINTS; i++)
                scale_pts[i] = POINT_RESET[i];
            moving_now = 1'b0;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_START)
                start_thr = val;
            else if (idx == REG_KEEP)
                keep_thr = val;
            else if (idx >= REG_POINT0 && idx < REG_POINT0 + MAX_POINTS)
                scale_pts[idx - REG_POINT0] = val;
        endfunction

        function longint abs_of(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function longint pt_duty(int i);
            return longint'(scale_pts[i][15:0]);
        endfunction

        function longint pt_scale(int i);
            return longint'(scale_pts[i][31:16]);
        endfunction

        // piecewise-linear right scale, clamped at both ends
        function longint right_scale(longint d);
            int     i;
            longint d0, d1, s0, s1, span, num, q;
            if (d <= pt_duty(0))
                return pt_scale(0);
            if (d >= pt_duty(SCALE_POINTS_DEF - 1))
                return pt_scale(SCALE_POINTS_DEF - 1);
            for (i = 0; i + 1 < SCALE_POINTS_DEF; i++)
            begin
                d0 = pt_duty(i);
                d1 = pt_duty(i + 1);
                if (d >= d0 && d <= d1)
                begin
                    span = d1 - d0;
                    if (span == 0)
                        return pt_scale(i);
                    s0  = pt_scale(i);
                    s1  = pt_scale(i + 1);
                    num = (d - d0) * (s1 - s0);
                    q   = abs_of(num) / span;
                    return s0 + ((num < 0) ? -q : q);
                end
            end
            // no bracketing pair in an unordered table
            return longint'(ONE_Q14);
        endfunction

        function longint scaled(longint v, longint s);
            longint m;
            m = (abs_of(v) * s) >> 14;
            return (v < 0) ? -m : m;
        endfunction

        function void gate_wheels(inout longint l, inout longint r);
            bit [31:0] thr;
            longint    min_l, min_r;
            if (l > 0 || r > 0)
            begin
                thr   = moving_now ? keep_thr : start_thr;
                min_l = longint'(thr[15:0]);
                min_r = longint'(thr[31:16]);
                if (l < min_l || r < min_r)
                begin
                    l = 0;
                    r = 0;
                    moving_now = 1'b0;
                end
                else
                begin
                    moving_now = 1'b1;
                end
            end
            else
            begin
                l = 0;
                r = 0;
                moving_now = 1'b0;
            end
        endfunction

        function logic signed [15:0] clip16(longint v);
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return 16'(v);
        endfunction

        function out_item_t mix_command(in_item_t cmd);
            longint    a, b, l, r, peak, ql, qr;
            out_item_t res;
            a = longint'($signed(cmd.duty_a));
            b = longint'($signed(cmd.duty_b));
            if (cmd.kind[KIND_RAW_BIT])
            begin
                l = a;
                r = b;
                moving_now = (a != 0 || b != 0);
            end
            else if (cmd.kind == KIND_DIFF)
            begin
                l = a + b;
                r = a - b;
                peak = (abs_of(l) > abs_of(r)) ? abs_of(l) : abs_of(r);
                if (peak > longint'(ONE_Q15))
                begin
                    ql = (abs_of(l) << 15) / peak;
                    qr = (abs_of(r) << 15) / peak;
                    l  = (l < 0) ? -ql : ql;
                    r  = (r < 0) ? -qr : qr;
                end
                if (a > 0 && abs_of(b) < longint'(ANG_LIMIT))
                    r = scaled(r, right_scale(abs_of(r)));
                gate_wheels(l, r);
            end
            else
            begin
                l = a;
                r = a;
                if (cmd.apply_scale && a > 0)
                    r = scaled(a, right_scale(a));
                gate_wheels(l, r);
            end
            res.left_duty  = clip16(l);
            res.right_duty = clip16(r);
            res.moving     = moving_now;
            return res;
        endfunction

        function void note_command(in_item_t cmd);
            expected_duties = {expected_duties, mix_command(cmd)};
        endfunction

        function int pending();
            return expected_duties.size();
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch %0d at %0t: %s", mismatches, $realtime, msg);
        endtask

        task check_duties(out_item_t got);
            out_item_t want;
            if (expected_duties.size() == 0)
            begin
                report($sformatf("result with nothing expected: %h", got));
                return;
            end
            want = expected_duties.pop_front();
            if (got.left_duty !== want.left_duty)
                report($sformatf("left_duty %0d, expected %0d",
                                 got.left_duty, want.left_duty));
            if (got.right_duty !== want.right_duty)
                report($sformatf("right_duty %0d, expected %0d",
                                 got.right_duty, want.right_duty));
            if (got.moving !== want.moving)
                report($sformatf("moving %b, expected %b", got.moving, want.moving));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    duty_pair_tracker duties;

    // receiver stall pattern state
    int stall_mode = 0;
    int mode_left  = 0;
    int hold_left  = 0;
    bit hold_level = 1'b0;

    // watchdog
    int quiet_cycles = 0;

    // random walk used to build runs of similar forward commands
    int cruise_duty = 2000;

    // register values staged for the next phase
    bit [31:0] plan_pts [MAX_POINTS];

    always #HALF_PERIOD clk = ~clk;

    skid_steer_duty_mixer #(
        .SCALE_POINTS (SCALE_POINTS_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // result side: sample at the rising edge, compare in arrival order
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            duties.check_duties(out_data);
    end

    // receiver stalls: a random mode, redrawn when its countdown runs out
    // mode 0 never stalls, 1 light random, 2 heavy random, 3 long on/off runs
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(3);
            mode_left  = $urandom_range(50, 400);
        end
        else
        begin
            mode_left--;
        end
        case (stall_mode)
            0: out_stall = 1'b0;
            1: out_stall = ($urandom_range(3) == 0);
            2: out_stall = ($urandom_range(9) < 6);
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_left  = $urandom_range(1, 20);
                    hold_level = ~hold_level;
                end
                else
                begin
                    hold_left--;
                end
                out_stall = hold_level;
            end
        endcase
    end

    // watchdog: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drive tasks, all called and returning at a falling edge
    // ------------------------------------------------------------------------

    // one request: hold valid and payload until accepted
    task automatic send_command(in_item_t cmd);
        in_valid = 1'b1;
        in_data  = cmd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        duties.note_command(cmd);
        @(negedge clk);
    endtask

    task automatic send_fields(logic [1:0] kind, int a, int b, bit apply);
        in_item_t cmd;
        cmd.kind        = kind;
        cmd.duty_a      = 16'(a);
        cmd.duty_b      = 16'(b);
        cmd.apply_scale = apply;
        send_command(cmd);
    endtask

    // let every outstanding request come back
    task automatic wait_drained();
        while (duties.pending() != 0)
            @(negedge clk);
    endtask

    // register write; caller lowers cfg_valid after the last one
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        duties.set_register(idx, val);
        @(negedge clk);
    endtask

    // ascending table, optionally with one pair of equal duties
    task automatic plan_ascending(bit equal_pair, int scale_lo, int scale_hi);
        int i;
        int d;
        d = $urandom_range(0, 2000);
        for (i = 0; i < MAX_POINTS; i++)
        begin
            if (i > 0 && !(equal_pair && i == 3))
                d = d + $urandom_range(1, 6000);
            if (d > 32767)
                d = 32767;
            plan_pts[i] = {16'($urandom_range(scale_lo, scale_hi)), 16'(d)};
        end
    endtask

    function automatic bit [31:0] small_pair();
        return {16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000))};
    endfunction

    // one register setting per phase, extremes included
    task automatic load_setting(int which);
        bit [31:0] start_v;
        bit [31:0] keep_v;
        int        i;
        start_v = small_pair();
        keep_v  = small_pair();
        case (which)
            0: plan_ascending(1'b0, 8000, 24000);
            1:
            begin
                // no threshold at all, large scales push the right wheel to saturation
                start_v = '0;
                keep_v  = '0;
                plan_ascending(1'b0, 16384, 65535);
            end
            2:
            begin
                // thresholds at the top: non-raw commands gated to standstill
                start_v = '1;
                keep_v  = '1;
                for (i = 0; i < MAX_POINTS; i++)
                    plan_pts[i] = '1;
            end
            3: plan_ascending(1'b1, 0, 40000);
            4:
            begin
                // unordered table
                for (i = 0; i < MAX_POINTS; i++)
                    plan_pts[i] = {16'($urandom), 1'b0, 15'($urandom)};
            end
            5:
            begin
                start_v = '0;
                keep_v  = $urandom;
                for (i = 0; i < MAX_POINTS; i++)
                    plan_pts[i] = '0;
            end
            default:
            begin
                start_v = START_RESET;
                keep_v  = KEEP_RESET;
                for (i = 0; i < MAX_POINTS; i++)
                    plan_pts[i] = POINT_RESET[i];
            end
        endcase
        write_reg(REG_START, start_v);
        write_reg(REG_KEEP, keep_v);
        for (i = 0; i < MAX_POINTS; i++)
            write_reg(REG_POINT0 + CFG_INDEX_W'(i), plan_pts[i]);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // random requests: mostly forward drive near the thresholds and near
    // straight, so the moving flag and the scaling path both see real traffic
    // ------------------------------------------------------------------------
    function automatic int pick_duty();
        int p;
        p = $urandom_range(99);
        if (p < 15)
            return $signed(16'($urandom));
        if (p < 25)
        begin
            case ($urandom_range(5))
                0: return -32768;
                1: return -1;
                2: return 0;
                3: return 1;
                4: return 32767;
                default: return 16384;
            endcase
        end
        if (p < 50)
        begin
            cruise_duty = cruise_duty + $urandom_range(0, 1600) - 800;
            if (cruise_duty < 0)
                cruise_duty = 0;
            if (cruise_duty > 32767)
                cruise_duty = 32767;
            return cruise_duty;
        end
        if (p < 80)
            return $urandom_range(0, 32767);
        return $urandom_range(0, 8000);
    endfunction

    function automatic int pick_angle();
        int p;
        int m;
        p = $urandom_range(99);
        if (p < 50)
        begin
            m = $urandom_range(0, 3276);
            return $urandom_range(1) ? -m : m;
        end
        if (p < 60)
        begin
            case ($urandom_range(4))
                0: return 3276;
                1: return 3277;
                2: return -3276;
                3: return -3277;
                default: return 0;
            endcase
        end
        if (p < 80)
            return $signed(16'($urandom));
        m = $urandom_range(0, 12000);
        return $urandom_range(1) ? -m : m;
    endfunction

    function automatic in_item_t random_command();
        in_item_t cmd;
        int       p;
        p = $urandom_range(99);
        cmd.apply_scale = ($urandom_range(9) < 7);
        cmd.duty_b      = 16'($urandom);
        if (p < 35)
        begin
            cmd.kind = KIND_SINGLE;
            // land exactly on table points now and then
            if ($urandom_range(7) == 0)
                cmd.duty_a = duties.scale_pts[$urandom_range(SCALE_POINTS_DEF - 1)][15:0];
            else
                cmd.duty_a = 16'(pick_duty());
        end
        else if (p < 75)
        begin
            cmd.kind   = KIND_DIFF;
            cmd.duty_a = 16'(pick_duty());
            cmd.duty_b = 16'(pick_angle());
        end
        else
        begin
            cmd.kind = (p < 92) ? KIND_RAW : KIND_RAW_HI;
            if ($urandom_range(4) == 0)
            begin
                cmd.duty_a = '0;
                cmd.duty_b = '0;
            end
            else
            begin
                cmd.duty_a = 16'($urandom);
            end
        end
        return cmd;
    endfunction

    // bursts of back-to-back requests with random gaps between them
    task automatic run_random(int count, int gap_max, bit pause_midway);
        int k;
        int burst_left;
        int gap;
        burst_left = 0;
        for (k = 0; k < count; k++)
        begin
            if (pause_midway && k == count / 2)
            begin
                // hold off until the block has handed back everything
                in_valid = 1'b0;
                wait_drained();
                @(negedge clk);
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                if (gap > 0)
                begin
                    in_valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            send_command(random_command());
        end
        in_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    int phase_gap [NUM_PHASES] = '{20, 0, 30, 5, 25, 10, 0, 15};
    int ph;

    initial
    begin
        duties = new();
        rst_n  = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed requests at the reset register values
        send_fields(KIND_SINGLE, 0, 0, 1'b1);            // standstill stays put
        send_fields(KIND_SINGLE, 32767, -1, 1'b1);       // full forward, scaled
        send_fields(KIND_SINGLE, 32767, 0, 1'b0);        // full forward, keep pair
        send_fields(KIND_SINGLE, -32768, -1, 1'b1);      // negative, scaling skipped
        send_fields(KIND_SINGLE, 1, 0, 1'b1);            // below start threshold
        send_fields(KIND_SINGLE, 1000, 0, 1'b1);
        send_fields(KIND_SINGLE, 1400, 0, 1'b0);         // just above start pair
        send_fields(KIND_SINGLE, 1000, 0, 1'b0);         // held by keep pair
        send_fields(KIND_DIFF, 32767, 32767, 1'b0);      // normalization by the sum
        send_fields(KIND_DIFF, -32768, -32768, 1'b1);
        send_fields(KIND_DIFF, 32767, -32768, 1'b0);     // normalization by the difference
        send_fields(KIND_DIFF, 16384, 0, 1'b0);          // straight ahead, scaled
        send_fields(KIND_DIFF, 16384, 3276, 1'b0);       // widest near-straight turn
        send_fields(KIND_DIFF, 16384, 3277, 1'b0);       // first unscaled turn
        send_fields(KIND_DIFF, 16384, -3276, 1'b0);
        send_fields(KIND_DIFF, 20000, -3277, 1'b1);
        send_fields(KIND_DIFF, 0, 0, 1'b0);
        send_fields(KIND_DIFF, -100, 50, 1'b0);
        send_fields(KIND_RAW, 32767, -32768, 1'b1);      // raw passes straight through
        send_fields(KIND_RAW, 0, 0, 1'b0);
        send_fields(KIND_RAW_HI, 5, -5, 1'b0);           // kind three behaves as raw
        send_fields(KIND_SINGLE, 900, 0, 1'b1);          // after raw moving, keep pair
        send_fields(KIND_RAW_HI, 0, 0, 1'b1);

        // random phases, registers reloaded only with nothing in flight
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            in_valid = 1'b0;
            wait_drained();
            if (ph > 0)
                load_setting(ph - 1);
            run_random(PHASE_ITEMS, phase_gap[ph], ph == 2);
        end

        in_valid = 1'b0;
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (duties.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ skid_steer_duty_mixer.f @@
+incdir+src
src/ssdm_pkg.sv
src/ssdm_div.sv
src/skid_steer_duty_mixer.sv
verif/skid_steer_duty_mixer_tb.sv
